// ===== rtl/asw_pkg.sv =====
// Shared constants, types and codes for the allpass stereo widener.
// No dependencies; every other file in rtl/ imports this package.
package asw_pkg;

   localparam int STAGE_COUNT = 21;
   localparam int SAMPLE_BITS = 24;
   localparam int STAGE_BITS  = $clog2(STAGE_COUNT);
   localparam int FRAC_BITS   = 23;
   localparam int WIDTH_BITS  = 24;
   localparam int PAN_BITS    = 25;
   localparam int COEF_BITS   = 25;
   localparam int OPND_BITS   = (SAMPLE_BITS + 1 > PAN_BITS) ? SAMPLE_BITS + 1 : PAN_BITS;
   localparam int PROD_BITS   = 2 * OPND_BITS;
   localparam int SUM_BITS    = PROD_BITS + 1;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [STAGE_BITS-1:0] TOP_STAGE = STAGE_BITS'(STAGE_COUNT - 1);

   typedef enum logic [1:0] {
      REG_STEREO_WIDTH  = 2'd0,
      REG_PAN_COSINE    = 2'd1,
      REG_PAN_SINE      = 2'd2,
      REG_BYPASS_ENABLE = 2'd3
   } asw_reg_type;

   typedef struct packed {
      logic        [WIDTH_BITS-1:0] stereo_width;
      logic signed [PAN_BITS-1:0]   pan_cosine;
      logic signed [PAN_BITS-1:0]   pan_sine;
      logic                         bypass_enable;
   } asw_cfg_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_STAGE_MUL,
      OP_STAGE_ACC,
      OP_MUL_XW,
      OP_FORM_L,
      OP_MUL_A2W,
      OP_FORM_R,
      OP_MUL_LC,
      OP_MUL_RS,
      OP_SUM_LEFT,
      OP_MUL_RC,
      OP_MUL_LS,
      OP_DIFF_RIGHT,
      OP_BYPASS,
      OP_PUBLISH
   } asw_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STAGE_MUL,
      ST_STAGE_ACC,
      ST_MUL_XW,
      ST_FORM_L,
      ST_MUL_A2W,
      ST_FORM_R,
      ST_MUL_LC,
      ST_MUL_RS,
      ST_SUM_LEFT,
      ST_MUL_RC,
      ST_MUL_LS,
      ST_DIFF_RIGHT,
      ST_BYPASS,
      ST_PUBLISH
   } asw_state_type;

   typedef struct packed {
      asw_op_type            op;
      logic                  chain;
      logic [STAGE_BITS-1:0] stage;
   } asw_cmd_type;

endpackage

// ===== rtl/allpass_stereo_widener_unit.sv =====
// Top level of the allpass stereo widener: CSR bank, sequencer and datapath.
// Depends on asw_pkg, asw_csr, asw_ctrl and asw_datapath.
//
//   port group   direction  transfer when                  payload
//   req_*        in         req_valid & !req_stall         req_mono_sample
//   rsp_*        out        rsp_valid & !rsp_stall         rsp_left_sample, rsp_right_sample
//   APB (p*)     in/out     psel & penable & pwrite        pwdata at paddr, 4 bytes per register
//
// Filtering is set by the single shared multiplier: each allpass stage of both cascades
// takes a multiply step and a round/add step, then the mix steps run and the output register
// is loaded. Bypass skips the cascades and mix; a new sample waits until the last is published.
// Synchronous active-high reset clears the delay lines and control state and sets the CSRs to defaults.
// A result waits in the output register under rsp_stall while the next sample is taken.
module allpass_stereo_widener_unit import asw_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_mono_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_sample,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_sample,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      paddr,
   input  logic [CSR_DATA_BITS-1:0]      pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   asw_cfg_type cfg;
   asw_cmd_type cmd;

   asw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   asw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .bypass_enable (cfg.bypass_enable),
      .cmd           (cmd)
   );

   asw_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg),
      .req_mono_sample  (req_mono_sample),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample)
   );

endmodule

// ===== rtl/asw_csr.sv =====
// Configuration register bank behind the APB-style port.
// Depends on asw_pkg for register codes and the config struct.
module asw_csr import asw_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output asw_cfg_type              cfg
);

   asw_cfg_type cfg_ff;
   asw_cfg_type cfg_in;
   asw_reg_type reg_sel;
   logic        wr_en;

   assign reg_sel = asw_reg_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_STEREO_WIDTH:  cfg_in.stereo_width  = pwdata[WIDTH_BITS-1:0];
            REG_PAN_COSINE:    cfg_in.pan_cosine    = pwdata[PAN_BITS-1:0];
            REG_PAN_SINE:      cfg_in.pan_sine      = pwdata[PAN_BITS-1:0];
            REG_BYPASS_ENABLE: cfg_in.bypass_enable = pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_STEREO_WIDTH:  prdata = CSR_DATA_BITS'(cfg_ff.stereo_width);
         REG_PAN_COSINE:    prdata = CSR_DATA_BITS'(cfg_ff.pan_cosine);
         REG_PAN_SINE:      prdata = CSR_DATA_BITS'(cfg_ff.pan_sine);
         REG_BYPASS_ENABLE: prdata = CSR_DATA_BITS'(cfg_ff.bypass_enable);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stereo_width  <= '0;
         cfg_ff.pan_cosine    <= PAN_BITS'(1 << FRAC_BITS);
         cfg_ff.pan_sine      <= '0;
         cfg_ff.bypass_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/asw_ctrl.sv =====
// Sequencer: walks both allpass cascades stage by stage, then the mix steps, or takes the bypass path.
// Depends on asw_pkg for state, op and command types.
module asw_ctrl import asw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        bypass_enable,
   output asw_cmd_type cmd
);

   asw_state_type         state_ff, state_in;
   logic [STAGE_BITS-1:0] stage_ff, stage_in;
   logic                  chain_ff, chain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      stage_in = stage_ff;
      chain_in = chain_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (bypass_enable) begin
                  state_in = ST_BYPASS;
               end else begin
                  state_in = ST_STAGE_MUL;
                  stage_in = TOP_STAGE;
                  chain_in = 1'b0;
               end
            end
         end
         ST_STAGE_MUL: state_in = ST_STAGE_ACC;
         ST_STAGE_ACC: begin
            if (stage_ff == '0) begin
               if (!chain_ff) begin
                  chain_in = 1'b1;
                  stage_in = TOP_STAGE;
                  state_in = ST_STAGE_MUL;
               end else begin
                  state_in = ST_MUL_XW;
               end
            end else begin
               stage_in = stage_ff - 1'b1;
               state_in = ST_STAGE_MUL;
            end
         end
         ST_MUL_XW:     state_in = ST_FORM_L;
         ST_FORM_L:     state_in = ST_MUL_A2W;
         ST_MUL_A2W:    state_in = ST_FORM_R;
         ST_FORM_R:     state_in = ST_MUL_LC;
         ST_MUL_LC:     state_in = ST_MUL_RS;
         ST_MUL_RS:     state_in = ST_SUM_LEFT;
         ST_SUM_LEFT:   state_in = ST_MUL_RC;
         ST_MUL_RC:     state_in = ST_MUL_LS;
         ST_MUL_LS:     state_in = ST_DIFF_RIGHT;
         ST_DIFF_RIGHT: state_in = ST_PUBLISH;
         ST_BYPASS:     state_in = ST_PUBLISH;
         ST_PUBLISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.chain    = chain_ff;
      cmd.stage    = stage_ff;
      req_stall    = (state_ff != ST_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE:       cmd.op = req_valid ? OP_LOAD : OP_IDLE;
         ST_STAGE_MUL:  cmd.op = OP_STAGE_MUL;
         ST_STAGE_ACC:  cmd.op = OP_STAGE_ACC;
         ST_MUL_XW:     cmd.op = OP_MUL_XW;
         ST_FORM_L:     cmd.op = OP_FORM_L;
         ST_MUL_A2W:    cmd.op = OP_MUL_A2W;
         ST_FORM_R:     cmd.op = OP_FORM_R;
         ST_MUL_LC:     cmd.op = OP_MUL_LC;
         ST_MUL_RS:     cmd.op = OP_MUL_RS;
         ST_SUM_LEFT:   cmd.op = OP_SUM_LEFT;
         ST_MUL_RC:     cmd.op = OP_MUL_RC;
         ST_MUL_LS:     cmd.op = OP_MUL_LS;
         ST_DIFF_RIGHT: cmd.op = OP_DIFF_RIGHT;
         ST_BYPASS:     cmd.op = OP_BYPASS;
         ST_PUBLISH: begin
            cmd.op = out_free ? OP_PUBLISH : OP_IDLE;
            if (out_free) begin
               rsp_valid_in = 1'b1;
            end
         end
         default:       cmd.op = OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stage_ff     <= '0;
         chain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stage_ff     <= stage_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/asw_datapath.sv =====
// Datapath: allpass delay state, shared multiplier, round/saturate, mix, output register.
// Depends on asw_pkg; driven by command struct from asw_ctrl.
module asw_datapath import asw_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  asw_cmd_type                   cmd,
   input  asw_cfg_type                   cfg,
   input  logic signed [SAMPLE_BITS-1:0] req_mono_sample,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_sample,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_sample
);

   localparam logic signed [SUM_BITS-1:0] SAT_HI =
      SUM_BITS'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
   localparam logic signed [SUM_BITS-1:0] SAT_LO =
      SUM_BITS'(-(longint'(1) <<< (SAMPLE_BITS - 1)));
   localparam logic signed [SUM_BITS-1:0] RND_HALF =
      SUM_BITS'(longint'(1) <<< (FRAC_BITS - 1));

   function automatic logic signed [COEF_BITS-1:0] stage_coef(
      input logic [STAGE_BITS-1:0] idx
   );
      unique case (idx)
         STAGE_BITS'(0):  return COEF_BITS'(-8240391);
         STAGE_BITS'(1),
         STAGE_BITS'(2):  return COEF_BITS'(-8253001);
         STAGE_BITS'(3),
         STAGE_BITS'(4):  return COEF_BITS'(-8257707);
         STAGE_BITS'(5),
         STAGE_BITS'(6):  return COEF_BITS'(-8263121);
         STAGE_BITS'(7),
         STAGE_BITS'(8):  return COEF_BITS'(-8268307);
         STAGE_BITS'(9),
         STAGE_BITS'(10): return COEF_BITS'(-8278680);
         STAGE_BITS'(11),
         STAGE_BITS'(12): return COEF_BITS'(-8299719);
         STAGE_BITS'(13),
         STAGE_BITS'(14): return COEF_BITS'(-8306684);
         STAGE_BITS'(15),
         STAGE_BITS'(16),
         STAGE_BITS'(17),
         STAGE_BITS'(18): return COEF_BITS'(-8314395);
         STAGE_BITS'(19),
         STAGE_BITS'(20): return COEF_BITS'(-8328350);
         default:         return '0;
      endcase
   endfunction

   function automatic logic signed [SUM_BITS-1:0] rnd(input logic signed [SUM_BITS-1:0] v);
      return (v + RND_HALF) >>> FRAC_BITS;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SUM_BITS-1:0] v);
      if (v > SAT_HI) begin
         return SAT_HI[SAMPLE_BITS-1:0];
      end else if (v < SAT_LO) begin
         return SAT_LO[SAMPLE_BITS-1:0];
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   // per-cascade delay lines
   logic signed [SAMPLE_BITS-1:0] xd0_ff [STAGE_COUNT];
   logic signed [SAMPLE_BITS-1:0] yd0_ff [STAGE_COUNT];
   logic signed [SAMPLE_BITS-1:0] xd1_ff [STAGE_COUNT];
   logic signed [SAMPLE_BITS-1:0] yd1_ff [STAGE_COUNT];

   logic signed [SAMPLE_BITS-1:0] sig_ff, x_ff, a1_ff, l_ff, r_ff;
   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff, out_left_ff, out_right_ff;
   logic signed [PROD_BITS-1:0]   prod_ff, acc_ff;

   logic signed [SAMPLE_BITS-1:0] xd_sel, yd_sel, stage_y;
   logic signed [OPND_BITS-1:0]   diff, width_ext, mul_a, mul_b;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic signed [SUM_BITS-1:0]    prod_rnd, prod_ext, acc_ext;

   assign xd_sel    = cmd.chain ? xd1_ff[cmd.stage] : xd0_ff[cmd.stage];
   assign yd_sel    = cmd.chain ? yd1_ff[cmd.stage] : yd0_ff[cmd.stage];
   assign diff      = OPND_BITS'(sig_ff) - OPND_BITS'(yd_sel);
   assign width_ext = signed'(OPND_BITS'(cfg.stereo_width));
   assign prod_ext  = SUM_BITS'(prod_ff);
   assign acc_ext   = SUM_BITS'(acc_ff);
   assign prod_rnd  = rnd(prod_ext);
   assign stage_y   = sat(prod_rnd + SUM_BITS'(xd_sel));

   always_comb begin
      unique case (cmd.op)
         OP_STAGE_MUL: begin
            mul_a = diff;
            mul_b = OPND_BITS'(stage_coef(cmd.stage));
         end
         OP_MUL_XW: begin
            mul_a = OPND_BITS'(x_ff);
            mul_b = width_ext;
         end
         OP_MUL_A2W: begin
            mul_a = OPND_BITS'(sig_ff);
            mul_b = width_ext;
         end
         OP_MUL_LC: begin
            mul_a = OPND_BITS'(l_ff);
            mul_b = OPND_BITS'(cfg.pan_cosine);
         end
         OP_MUL_RS: begin
            mul_a = OPND_BITS'(r_ff);
            mul_b = OPND_BITS'(cfg.pan_sine);
         end
         OP_MUL_RC: begin
            mul_a = OPND_BITS'(r_ff);
            mul_b = OPND_BITS'(cfg.pan_cosine);
         end
         OP_MUL_LS: begin
            mul_a = OPND_BITS'(l_ff);
            mul_b = OPND_BITS'(cfg.pan_sine);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // allpass delay state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STAGE_COUNT; i++) begin
            xd0_ff[i] <= '0;
            yd0_ff[i] <= '0;
            xd1_ff[i] <= '0;
            yd1_ff[i] <= '0;
         end
      end else if (cmd.op == OP_STAGE_ACC) begin
         if (cmd.chain) begin
            xd1_ff[cmd.stage] <= sig_ff;
            yd1_ff[cmd.stage] <= stage_y;
         end else begin
            xd0_ff[cmd.stage] <= sig_ff;
            yd0_ff[cmd.stage] <= stage_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            sig_ff <= req_mono_sample;
            x_ff   <= req_mono_sample;
         end
         OP_STAGE_MUL, OP_MUL_XW, OP_MUL_A2W, OP_MUL_LC, OP_MUL_RC: begin
            prod_ff <= prod_in;
         end
         OP_MUL_RS, OP_MUL_LS: begin
            acc_ff  <= prod_ff;
            prod_ff <= prod_in;
         end
         OP_STAGE_ACC: begin
            sig_ff <= stage_y;
            if (!cmd.chain) begin
               a1_ff <= stage_y;
            end
         end
         OP_FORM_L:     l_ff     <= sat(prod_rnd + SUM_BITS'(a1_ff));
         OP_FORM_R:     r_ff     <= sat(SUM_BITS'(a1_ff) - prod_rnd);
         OP_SUM_LEFT:   left_ff  <= sat(rnd(acc_ext + prod_ext));
         OP_DIFF_RIGHT: right_ff <= sat(rnd(acc_ext - prod_ext));
         OP_BYPASS: begin
            left_ff  <= x_ff;
            right_ff <= x_ff;
         end
         OP_PUBLISH: begin
            out_left_ff  <= left_ff;
            out_right_ff <= right_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_left_sample  = out_left_ff;
   assign rsp_right_sample = out_right_ff;

endmodule
